### rtl/appm_pkg.sv
// Package: shared constants and phase type for the AC peak and period meter.
package appm_pkg;

  localparam int SAMPLE_BITS_DEF = 14;
  localparam int COUNT_BITS_DEF  = 24;

  // Threshold reset codes
  localparam int CH1_THR_RST = 248;
  localparam int CH2_THR_RST = 99;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CH1_THR = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CH2_THR = 1'b1;

  typedef enum logic [2:0] {
    PH_BOTH_LOW   = 3'd0,
    PH_CH1_RISE   = 3'd1,
    PH_CH1_HUMP   = 3'd2,
    PH_CH1_VALLEY = 3'd3,
    PH_CH2_LOW    = 3'd4,
    PH_CH2_RISE   = 3'd5,
    PH_CH2_HUMP   = 3'd6,
    PH_CH2_VALLEY = 3'd7
  } phase_e;

endpackage

### rtl/appm_in_if.sv
// Interface: sample pair channel.
interface appm_in_if #(
  parameter int SAMPLE_BITS = appm_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] ch1_sample;
  logic [SAMPLE_BITS-1:0] ch2_sample;

  modport source (output valid, output ch1_sample, output ch2_sample, input ready);
  modport sink   (input valid, input ch1_sample, input ch2_sample, output ready);
endinterface

### rtl/appm_out_if.sv
// Interface: measurement result channel.
interface appm_out_if #(
  parameter int SAMPLE_BITS = appm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = appm_pkg::COUNT_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_BITS:0]    ch1_period;
  logic [SAMPLE_BITS-1:0] ch1_peak;
  logic [COUNT_BITS-1:0]  ch2_period;
  logic [SAMPLE_BITS-1:0] ch2_peak;
  logic                   count_saturated;

  modport source (output valid, output ch1_period, output ch1_peak, output ch2_period,
                  output ch2_peak, output count_saturated, input ready);
  modport sink   (input valid, input ch1_period, input ch1_peak, input ch2_period,
                  input ch2_peak, input count_saturated, output ready);
endinterface

### rtl/appm_in_stage.sv
// Input register stage: holds one sample pair until the sequencer consumes it.
module appm_in_stage #(
  parameter int SAMPLE_BITS = appm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  appm_in_if.sink                sample_i,
  input  logic                   advance_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS-1:0] s1_o,
  output logic [SAMPLE_BITS-1:0] s2_o
);

  logic                   valid_q;
  logic [SAMPLE_BITS-1:0] s1_q;
  logic [SAMPLE_BITS-1:0] s2_q;
  logic                   take;

  assign sample_i.ready = !valid_q || advance_i;
  assign take           = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= sample_i.ch1_sample;
      s2_q <= sample_i.ch2_sample;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;
  assign s2_o    = s2_q;

endmodule

### rtl/appm_seq.sv
// Measurement sequencer: phase machine, peaks, tick counter and result register.
module appm_seq #(
  parameter int SAMPLE_BITS = appm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = appm_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] s1_i,
  input  logic [SAMPLE_BITS-1:0] s2_i,
  input  logic [SAMPLE_BITS-1:0] ch1_thr_i,
  input  logic [SAMPLE_BITS-1:0] ch2_thr_i,
  output logic                   advance_o,
  appm_out_if.source             result_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  appm_pkg::phase_e       phase_q, phase_d;
  logic [SAMPLE_BITS-1:0] peak1_q, peak1_d;
  logic [SAMPLE_BITS-1:0] peak2_q, peak2_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [COUNT_BITS:0]    held_q, held_d;
  logic                   sat_q, sat_d;

  logic                   up1, up2;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic                   sat_inc;
  logic                   emit;

  logic                   res_valid_q;
  logic [COUNT_BITS:0]    res_period1_q;
  logic [SAMPLE_BITS-1:0] res_peak1_q;
  logic [COUNT_BITS-1:0]  res_period2_q;
  logic [SAMPLE_BITS-1:0] res_peak2_q;
  logic                   res_sat_q;

  assign up1 = s1_i > ch1_thr_i;
  assign up2 = s2_i > ch2_thr_i;

  // saturating tick count; the flag sets once the count sits at its maximum
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign sat_inc = sat_q || (cnt_inc == CNT_MAX);

  assign emit      = valid_i && (phase_q == appm_pkg::PH_CH2_VALLEY) && up2;
  assign advance_o = valid_i && (!emit || !res_valid_q || result_o.ready);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      appm_pkg::PH_BOTH_LOW:   if (!up1 && !up2) phase_d = appm_pkg::PH_CH1_RISE;
      appm_pkg::PH_CH1_RISE:   if (up1)  phase_d = appm_pkg::PH_CH1_HUMP;
      appm_pkg::PH_CH1_HUMP:   if (!up1) phase_d = appm_pkg::PH_CH1_VALLEY;
      appm_pkg::PH_CH1_VALLEY: if (up1)  phase_d = appm_pkg::PH_CH2_LOW;
      appm_pkg::PH_CH2_LOW:    if (!up2) phase_d = appm_pkg::PH_CH2_RISE;
      appm_pkg::PH_CH2_RISE:   if (up2)  phase_d = appm_pkg::PH_CH2_HUMP;
      appm_pkg::PH_CH2_HUMP:   if (!up2) phase_d = appm_pkg::PH_CH2_VALLEY;
      appm_pkg::PH_CH2_VALLEY: if (up2)  phase_d = appm_pkg::PH_BOTH_LOW;
      default:                 phase_d = appm_pkg::PH_BOTH_LOW;
    endcase
  end

  // datapath updates per phase
  always_comb begin
    peak1_d = peak1_q;
    peak2_d = peak2_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    sat_d   = sat_q;
    unique case (phase_q)
      appm_pkg::PH_BOTH_LOW: begin
        if (!up1 && !up2) begin
          peak1_d = '0;
          peak2_d = '0;
          cnt_d   = '0;
          sat_d   = 1'b0;
        end
      end
      appm_pkg::PH_CH1_RISE: begin
        if (up1) peak1_d = s1_i;
      end
      appm_pkg::PH_CH1_HUMP: begin
        if (!up1) begin
          cnt_d = '0;
        end else if (s1_i > peak1_q) begin
          peak1_d = s1_i;
        end
      end
      appm_pkg::PH_CH1_VALLEY: begin
        cnt_d = cnt_inc;
        sat_d = sat_inc;
        if (up1) held_d = {cnt_inc, 1'b0};
      end
      appm_pkg::PH_CH2_LOW: begin
      end
      appm_pkg::PH_CH2_RISE: begin
        if (up2) cnt_d = '0;
      end
      appm_pkg::PH_CH2_HUMP: begin
        cnt_d = cnt_inc;
        sat_d = sat_inc;
        if (up2 && (s2_i > peak2_q)) peak2_d = s2_i;
      end
      appm_pkg::PH_CH2_VALLEY: begin
        cnt_d = cnt_inc;
        sat_d = sat_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= appm_pkg::PH_BOTH_LOW;
      peak1_q <= '0;
      peak2_q <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      sat_q   <= 1'b0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      peak1_q <= peak1_d;
      peak2_q <= peak2_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance_o && emit) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && emit) begin
      res_period1_q <= held_q;
      res_peak1_q   <= peak1_q;
      res_period2_q <= cnt_inc;
      res_peak2_q   <= peak2_q;
      res_sat_q     <= sat_inc;
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.ch1_period      = res_period1_q;
  assign result_o.ch1_peak        = res_peak1_q;
  assign result_o.ch2_period      = res_period2_q;
  assign result_o.ch2_peak        = res_peak2_q;
  assign result_o.count_saturated = res_sat_q;

endmodule

### rtl/ac_peak_period_meter.sv
// Top level: AC peak and period meter with threshold registers.
//
//   port      dir   modport  word contents
//   sample_i  in    sink     ch1_sample, ch2_sample (one pair per tick)
//   result_o  out   source   ch1_period, ch1_peak, ch2_period, ch2_peak, count_saturated
//   cfg_*_i   in    -        threshold write: cfg_we_i, cfg_idx_i, cfg_data_i
//
// One sample pair per cycle while no result word is held untaken; the result of the word
// that closes a sequence passes the input register, then the result register.
// Throughput is set by the phase/count update, one sample per cycle.
// Reset clears phase, peaks, count and flag; thresholds return to 248 and 99.
// The input stage only stalls when a result word is held and not taken.
module ac_peak_period_meter #(
  parameter int SAMPLE_BITS = appm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = appm_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  appm_in_if.sink                          sample_i,
  appm_out_if.source                       result_o,
  input  logic                             cfg_we_i,
  input  logic [appm_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]           cfg_data_i
);

  logic [SAMPLE_BITS-1:0] ch1_thr_q;
  logic [SAMPLE_BITS-1:0] ch2_thr_q;
  logic                   stage_valid;
  logic [SAMPLE_BITS-1:0] stage_s1;
  logic [SAMPLE_BITS-1:0] stage_s2;
  logic                   advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch1_thr_q <= SAMPLE_BITS'(appm_pkg::CH1_THR_RST);
      ch2_thr_q <= SAMPLE_BITS'(appm_pkg::CH2_THR_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        appm_pkg::CFG_CH1_THR: ch1_thr_q <= cfg_data_i;
        appm_pkg::CFG_CH2_THR: ch2_thr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  appm_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .s1_o      (stage_s1),
    .s2_o      (stage_s2)
  );

  appm_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stage_valid),
    .s1_i      (stage_s1),
    .s2_i      (stage_s2),
    .ch1_thr_i (ch1_thr_q),
    .ch2_thr_i (ch2_thr_q),
    .advance_o (advance),
    .result_o  (result_o)
  );

endmodule

### bench/testbench.sv
// Testbench for the AC peak and period meter: sequence stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module testbench;
  localparam int SW          = appm_pkg::SAMPLE_BITS_DEF;
  localparam int CNT_W       = appm_pkg::COUNT_BITS_DEF;
  localparam int CODE_MAX    = (1 << SW) - 1;
  localparam int LATENCY     = 4;
  localparam int STALL_LIMIT = 2000;

  class meter_scoreboard;
    localparam int SW = appm_pkg::SAMPLE_BITS_DEF;
    localparam int CW = appm_pkg::COUNT_BITS_DEF;
    localparam logic [CW-1:0] TICK_MAX = {CW{1'b1}};

    typedef struct packed {
      logic [CW:0]   period1;
      logic [SW-1:0] peak1;
      logic [CW-1:0] period2;
      logic [SW-1:0] peak2;
      logic          sat;
    } measure_t;

    logic [SW-1:0]    thr1;
    logic [SW-1:0]    thr2;
    appm_pkg::phase_e step;
    logic [SW-1:0]    peak1;
    logic [SW-1:0]    peak2;
    logic [CW-1:0]    ticks;
    logic [CW:0]      period1;
    logic             sat;
    measure_t         pending_measures[$];
    int               mismatches;

    function new();
      thr1       = SW'(appm_pkg::CH1_THR_RST);
      thr2       = SW'(appm_pkg::CH2_THR_RST);
      step       = appm_pkg::PH_BOTH_LOW;
      peak1      = '0;
      peak2      = '0;
      ticks      = '0;
      period1    = '0;
      sat        = 1'b0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [appm_pkg::CFG_IDX_BITS-1:0] idx, logic [SW-1:0] val);
      if (idx == appm_pkg::CFG_CH1_THR) begin
        thr1 = val;
      end else begin
        thr2 = val;
      end
    endfunction

    // count stops at all ones and latches the flag there
    function void count_tick();
      if (ticks != TICK_MAX) begin
        ticks = ticks + 1'b1;
      end
      if (ticks == TICK_MAX) begin
        sat = 1'b1;
      end
    endfunction

    function void take_sample(logic [SW-1:0] s1, logic [SW-1:0] s2);
      logic     up1;
      logic     up2;
      measure_t m;
      up1 = s1 > thr1;
      up2 = s2 > thr2;
      case (step)
        appm_pkg::PH_CH1_RISE: begin
          if (up1) begin
            peak1 = s1;
            step  = appm_pkg::PH_CH1_HUMP;
          end
        end
        appm_pkg::PH_CH1_HUMP: begin
          if (up1) begin
            if (s1 > peak1) peak1 = s1;
          end else begin
            ticks = '0;
            step  = appm_pkg::PH_CH1_VALLEY;
          end
        end
        appm_pkg::PH_CH1_VALLEY: begin
          count_tick();
          if (up1) begin
            period1 = {ticks, 1'b0};
            step    = appm_pkg::PH_CH2_LOW;
          end
        end
        appm_pkg::PH_CH2_LOW: begin
          if (!up2) step = appm_pkg::PH_CH2_RISE;
        end
        appm_pkg::PH_CH2_RISE: begin
          if (up2) begin
            ticks = '0;
            step  = appm_pkg::PH_CH2_HUMP;
          end
        end
        appm_pkg::PH_CH2_HUMP: begin
          count_tick();
          // falling sample leaves the peak alone
          if (up2) begin
            if (s2 > peak2) peak2 = s2;
          end else begin
            step = appm_pkg::PH_CH2_VALLEY;
          end
        end
        appm_pkg::PH_CH2_VALLEY: begin
          count_tick();
          if (up2) begin
            m.period1 = period1;
            m.peak1   = peak1;
            m.period2 = ticks;
            m.peak2   = peak2;
            m.sat     = sat;
            pending_measures.push_back(m);
            step = appm_pkg::PH_BOTH_LOW;
          end
        end
        default: begin
          if (!up1 && !up2) begin
            peak1 = '0;
            peak2 = '0;
            ticks = '0;
            sat   = 1'b0;
            step  = appm_pkg::PH_CH1_RISE;
          end else begin
            step = appm_pkg::PH_BOTH_LOW;
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_measure(logic [CW:0] p1, logic [SW-1:0] k1, logic [CW-1:0] p2,
                       logic [SW-1:0] k2, logic flag);
      measure_t want;
      if (pending_measures.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = pending_measures.pop_front();
      if (p1 !== want.period1)
        report($sformatf("ch1_period got %0d expected %0d", p1, want.period1));
      if (k1 !== want.peak1)
        report($sformatf("ch1_peak got %0d expected %0d", k1, want.peak1));
      if (p2 !== want.period2)
        report($sformatf("ch2_period got %0d expected %0d", p2, want.period2));
      if (k2 !== want.peak2)
        report($sformatf("ch2_peak got %0d expected %0d", k2, want.peak2));
      if (flag !== want.sat)
        report($sformatf("count_saturated got %0b expected %0b", flag, want.sat));
    endtask
  endclass

  logic                              clk_i  = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i;
  logic [appm_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [SW-1:0]                     cfg_data_i;

  appm_in_if  #(.SAMPLE_BITS(SW))                    smp ();
  appm_out_if #(.SAMPLE_BITS(SW), .COUNT_BITS(CNT_W)) res ();

  ac_peak_period_meter #(.SAMPLE_BITS(SW), .COUNT_BITS(CNT_W)) u_dut (
    .clk_i,
    .rst_ni,
    .sample_i  (smp),
    .result_o  (res),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  meter_scoreboard sb = new();

  bit gaps_on     = 1'b1;
  int pairs_sent  = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int any_code();
    return int'($urandom_range(0, CODE_MAX));
  endfunction

  // at or below the threshold, leaning on the boundary
  function automatic int low_code(input int t);
    case ($urandom_range(0, 3))
      0:       return t;
      1:       return 0;
      default: return int'($urandom_range(0, t));
    endcase
  endfunction

  function automatic int high_code(input int t);
    case ($urandom_range(0, 3))
      0:       return t + 1;
      1:       return CODE_MAX;
      default: return int'($urandom_range(t + 1, CODE_MAX));
    endcase
  endfunction

  task automatic send_pair(input int s1, input int s2);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      smp.valid      <= 1'b0;
      smp.ch1_sample <= SW'(any_code());
      smp.ch2_sample <= SW'(any_code());
      repeat (gap) @(negedge clk_i);
    end
    smp.valid      <= 1'b1;
    smp.ch1_sample <= SW'(s1);
    smp.ch2_sample <= SW'(s2);
    do @(posedge clk_i); while (smp.ready !== 1'b1);
    sb.take_sample(SW'(s1), SW'(s2));
    pairs_sent++;
  endtask

  // occasionally swap in a random word to break the sequence
  task automatic send_noisy(input int s1, input int s2);
    if ($urandom_range(0, 15) == 0) begin
      send_pair(any_code(), any_code());
    end else begin
      send_pair(s1, s2);
    end
  endtask

  // one full measurement: both low, ch1 hump and valley, ch2 low, rise, hump, valley, rise
  task automatic run_sequence(input int t1, input int t2);
    repeat ($urandom_range(0, 2)) send_noisy(any_code(), any_code());
    send_noisy(low_code(t1), low_code(t2));
    repeat ($urandom_range(0, 3)) send_noisy(low_code(t1), any_code());
    send_noisy(high_code(t1), any_code());
    repeat ($urandom_range(0, 4)) send_noisy(high_code(t1), any_code());
    send_noisy(low_code(t1), any_code());
    repeat ($urandom_range(0, 4)) send_noisy(low_code(t1), any_code());
    send_noisy(high_code(t1), any_code());
    repeat ($urandom_range(0, 2)) send_noisy(any_code(), high_code(t2));
    send_noisy(any_code(), low_code(t2));
    repeat ($urandom_range(0, 3)) send_noisy(any_code(), low_code(t2));
    send_noisy(any_code(), high_code(t2));
    repeat ($urandom_range(0, 4)) send_noisy(any_code(), high_code(t2));
    send_noisy(any_code(), low_code(t2));
    repeat ($urandom_range(0, 4)) send_noisy(any_code(), low_code(t2));
    send_noisy(any_code(), high_code(t2));
  endtask

  // only written with the block drained
  task automatic write_threshold(input logic [appm_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (sb.pending_measures.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= SW'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(idx, SW'(val));
  endtask

  initial begin
    int stall;
    bit late;
    res.ready = 1'b0;
    forever begin
      stall = gaps_on ? $urandom_range(0, 18) : 0;
      late  = ($urandom_range(0, 1) == 1);
      @(negedge clk_i);
      if (stall > 0) begin
        res.ready <= 1'b0;
        if (late) begin
          do @(posedge clk_i); while (res.valid !== 1'b1);
        end
        repeat (stall) @(negedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (res.valid !== 1'b1);
      sb.check_measure(res.ch1_period, res.ch1_peak, res.ch2_period, res.ch2_peak,
                       res.count_saturated);
    end
  end

  initial begin
    int t1;
    int t2;
    int goal;
    smp.valid      = 1'b0;
    smp.ch1_sample = '0;
    smp.ch2_sample = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = appm_pkg::CFG_CH1_THR;
    cfg_data_i     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds 248 / 99; code equal to threshold counts as low
    send_pair(CODE_MAX, CODE_MAX);
    send_pair(248, 99);
    send_pair(248, CODE_MAX);
    send_pair(249, 0);
    send_pair(CODE_MAX, 5);
    send_pair(300, 7);
    send_pair(0, CODE_MAX);
    send_pair(100, 3);
    send_pair(CODE_MAX, 0);
    send_pair(1, CODE_MAX);
    send_pair(2, 99);
    send_pair(3, 100);
    send_pair(4, CODE_MAX);
    send_pair(5, 0);
    send_pair(6, 200);
    // shortest sequence; ch2 hump ends on its first tick so its peak stays zero
    send_pair(0, 0);
    send_pair(CODE_MAX, 0);
    send_pair(0, 0);
    send_pair(CODE_MAX, 0);
    send_pair(0, 0);
    send_pair(0, CODE_MAX);
    send_pair(0, 0);
    send_pair(0, CODE_MAX);

    // threshold at full scale: that channel can never rise
    write_threshold(appm_pkg::CFG_CH1_THR, CODE_MAX);
    write_threshold(appm_pkg::CFG_CH2_THR, 0);
    send_pair(CODE_MAX, 0);
    send_pair(CODE_MAX, CODE_MAX);
    send_pair(any_code(), any_code());
    write_threshold(appm_pkg::CFG_CH1_THR, 0);
    write_threshold(appm_pkg::CFG_CH2_THR, CODE_MAX);
    send_pair(1, CODE_MAX);
    send_pair(0, 0);
    send_pair(5, CODE_MAX);
    send_pair(0, CODE_MAX);
    send_pair(any_code(), CODE_MAX);

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: begin t1 = appm_pkg::CH1_THR_RST; t2 = appm_pkg::CH2_THR_RST; end
        1: begin t1 = 0;            t2 = 0;            end
        2: begin t1 = CODE_MAX - 1; t2 = CODE_MAX - 1; end
        3: begin t1 = 0;            t2 = CODE_MAX - 1; end
        default: begin
          t1 = int'($urandom_range(0, CODE_MAX - 1));
          t2 = int'($urandom_range(0, CODE_MAX - 1));
        end
      endcase
      write_threshold(appm_pkg::CFG_CH1_THR, t1);
      write_threshold(appm_pkg::CFG_CH2_THR, t2);
      gaps_on = (k != 4);
      goal = pairs_sent + 120;
      while (pairs_sent < goal) run_sequence(t1, t2);
    end

    gaps_on = 1'b1;
    write_threshold(appm_pkg::CFG_CH1_THR, 100);
    write_threshold(appm_pkg::CFG_CH2_THR, 100);
    repeat (3) run_sequence(100, 100);

    @(negedge clk_i);
    smp.valid <= 1'b0;
    while (sb.pending_measures.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_measures.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
